>>> src/mlpf_pkg.sv
// Package: shared constants, register map, control types and states of the local peak finder.
`timescale 1ns / 1ps
`default_nettype none
package mlpf_pkg;

  localparam int MAX_COLS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 16;

  localparam int ROW_W      = 10;
  localparam int PEAK_COL_W = 5;
  localparam int CFG_COLS_W = 6;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [ROW_W-1:0]      ROWS_RESET = ROW_W'(2);
  localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(2);

  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0]      row_count;
    logic [CFG_COLS_W-1:0] col_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_PUSH,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> src/mlpf_in_if.sv
// Interface: element request channel carrying one matrix value.
`timescale 1ns / 1ps
`default_nettype none
interface mlpf_in_if
  import mlpf_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

>>> src/mlpf_out_if.sv
// Interface: peak result request channel.
`timescale 1ns / 1ps
`default_nettype none
interface mlpf_out_if
  import mlpf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [ROW_W-1:0]      peak_row;
  logic [PEAK_COL_W-1:0] peak_col;
  logic                  last;

  modport source (output valid, output peak_row, output peak_col, output last, input ready);
  modport sink   (input valid, input peak_row, input peak_col, input last, output ready);
endinterface
`default_nettype wire

>>> src/mlpf_cfg.sv
// APB-style register block holding the matrix size registers.
`timescale 1ns / 1ps
`default_nettype none
module mlpf_cfg
  import mlpf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [ROW_W-1:0]      row_count_r, row_count_nxt;
  logic [CFG_COLS_W-1:0] col_count_r, col_count_nxt;
  reg_idx_t              idx;
  logic                  wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    prdata        = '0;
    unique case (idx)
      REG_ROW_COUNT: begin
        prdata = APB_DATA_W'(row_count_r);
        if (wr_en) row_count_nxt = pwdata[ROW_W-1:0];
      end
      REG_COL_COUNT: begin
        prdata = APB_DATA_W'(col_count_r);
        if (wr_en) col_count_nxt = pwdata[CFG_COLS_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROWS_RESET;
      col_count_r <= COLS_RESET;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

  assign cfg.row_count = row_count_r;
  assign cfg.col_count = col_count_r;

endmodule
`default_nettype wire

>>> src/mlpf_ram.sv
// Row ring memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mlpf_ram #(
  parameter int DEPTH = 96,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/matrix_local_peak_finder.sv
// Top level: 4-neighbour local maximum finder over a streamed matrix.
// Acceptance: row-0 elements are taken back to back; any other element blocks the input through
// accept, 4 ring reads with registered read data, compare and hand-over, set by the single read port.
// Results leave through an output register; a held-off result stalls the hand-over.
// The last element then sweeps the final row: per column reads, compare, push per extra peak.
// Synchronous active-low reset clears position, ring slot, sequencer and sizes (2 x 2).
`timescale 1ns / 1ps
`default_nettype none
module matrix_local_peak_finder
  import mlpf_pkg::*;
#(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mlpf_in_if.sink                    in_s,
  mlpf_out_if.source                 out_m,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int DEPTH = 3 * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int CCW   = (CNT_W > CFG_COLS_W) ? CNT_W : CFG_COLS_W;

  cfg_t cfg;

  mlpf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  mlpf_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_s.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic [AW-1:0] ring_addr(input logic [1:0] slot,
                                              input logic [COL_W-1:0] col);
    return AW'(slot) * AW'(MAX_COLS) + AW'(col);
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : 2'(s - 2'd1);
  endfunction

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : 2'(s + 2'd1);
  endfunction

  state_t state_r, state_nxt;

  logic [ROW_W-1:0]             row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]             col_cnt_r, col_cnt_nxt;
  logic [1:0]                   base_r, base_nxt;
  logic [2:0]                   step_r, step_nxt;
  logic                         flush_r, flush_nxt;
  logic [COL_W-1:0]             k_r, k_nxt;
  logic                         hold_v_r, hold_v_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic signed [VALUE_BITS-1:0] x_r, x_nxt;
  logic [ROW_W-1:0]             r_r, r_nxt;
  logic [COL_W-1:0]             c_r, c_nxt;
  logic [1:0]                   cur_r, cur_nxt;
  logic                         end_r, end_nxt;
  logic signed [VALUE_BITS-1:0] nb_r [4];
  logic [ROW_W-1:0]             cand_row_r, cand_row_nxt;
  logic [COL_W-1:0]             cand_col_r, cand_col_nxt;
  logic [ROW_W-1:0]             hold_row_r, hold_row_nxt;
  logic [COL_W-1:0]             hold_col_r, hold_col_nxt;
  logic [ROW_W-1:0]             out_row_r, out_row_nxt;
  logic [COL_W-1:0]             out_col_r, out_col_nxt;
  logic                         out_last_r, out_last_nxt;

  // size and position of an incoming element
  logic [ROW_W-1:0] rows_eff;
  logic [CCW-1:0]   col_ext, cols_eff;
  logic             wrap, in_last_col, in_last_elem, in_fire;
  logic [ROW_W-1:0] in_r;
  logic [COL_W-1:0] in_c;
  logic [1:0]       in_cur;

  assign rows_eff = (cfg.row_count < ROW_W'(2)) ? ROW_W'(2) : cfg.row_count;
  assign col_ext  = CCW'(cfg.col_count);
  assign cols_eff = (col_ext < CCW'(2)) ? CCW'(2) :
                    ((col_ext > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : col_ext);
  assign wrap     = (row_cnt_r >= rows_eff) || (CCW'(col_cnt_r) >= cols_eff);
  assign in_r     = wrap ? '0 : row_cnt_r;
  assign in_c     = wrap ? '0 : col_cnt_r;
  assign in_cur   = wrap ? 2'd0 : base_r;
  assign in_last_col  = (CCW'(in_c) + CCW'(1)) == cols_eff;
  assign in_last_elem = in_last_col && ((11'(in_r) + 11'd1) == 11'(rows_eff));

  assign in_s.ready = (state_r == ST_IDLE);
  assign in_fire    = in_s.valid && in_s.ready;
  assign ram_we     = in_fire;
  assign ram_waddr  = ring_addr(in_cur, in_c);

  // decision window
  logic [1:0]       up, up2, ctr_slot, n_slot;
  logic [COL_W-1:0] pos, pos_w, pos_e;
  logic             n_en, w_en, e_en, s_en, ok, slot_free;
  logic [1:0]       nb_idx;
  logic signed [VALUE_BITS-1:0] v;

  assign up       = slot_dec(cur_r);
  assign up2      = slot_inc(cur_r);
  assign pos      = flush_r ? k_r : c_r;
  assign ctr_slot = flush_r ? cur_r : up;
  assign n_slot   = flush_r ? up : up2;
  assign n_en     = flush_r || (r_r >= ROW_W'(2));
  assign w_en     = pos != '0;
  assign e_en     = (CCW'(pos) + CCW'(1)) < cols_eff;
  assign s_en     = !flush_r;
  assign pos_w    = w_en ? COL_W'(pos - COL_W'(1)) : pos;
  assign pos_e    = e_en ? COL_W'(pos + COL_W'(1)) : pos;
  assign nb_idx   = 2'(step_r[1:0] - 2'd1);
  assign v        = nb_r[0];
  assign ok       = (!s_en || (v >= x_r)) && (!n_en || (v >= nb_r[1])) &&
                    (!w_en || (v >= nb_r[2])) && (!e_en || (v >= nb_r[3]));
  assign slot_free = !out_valid_r || out_m.ready;

  always_comb begin
    unique case (step_r[1:0])
      2'd0:    ram_raddr = ring_addr(ctr_slot, pos);
      2'd1:    ram_raddr = ring_addr(n_slot, pos);
      2'd2:    ram_raddr = ring_addr(ctr_slot, pos_w);
      default: ram_raddr = ring_addr(ctr_slot, pos_e);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic adv_go;
    adv_go        = 1'b0;
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    col_cnt_nxt   = col_cnt_r;
    base_nxt      = base_r;
    step_nxt      = step_r;
    flush_nxt     = flush_r;
    k_nxt         = k_r;
    hold_v_nxt    = hold_v_r;
    out_valid_nxt = out_valid_r && !out_m.ready;
    x_nxt         = x_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    cand_row_nxt  = cand_row_r;
    cand_col_nxt  = cand_col_r;
    hold_row_nxt  = hold_row_r;
    hold_col_nxt  = hold_col_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          x_nxt     = in_s.value;
          r_nxt     = in_r;
          c_nxt     = in_c;
          cur_nxt   = in_cur;
          end_nxt   = in_last_elem;
          flush_nxt = 1'b0;
          step_nxt  = '0;
          if (in_last_elem) begin
            row_cnt_nxt = '0;
            col_cnt_nxt = '0;
            base_nxt    = 2'd0;
          end else if (in_last_col) begin
            row_cnt_nxt = ROW_W'(in_r + ROW_W'(1));
            col_cnt_nxt = '0;
            base_nxt    = slot_inc(in_cur);
          end else begin
            row_cnt_nxt = in_r;
            col_cnt_nxt = COL_W'(in_c + COL_W'(1));
            base_nxt    = in_cur;
          end
          if (in_r != '0) state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        step_nxt = 3'(step_r + 3'd1);
        if (step_r == 3'd4) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cand_row_nxt = flush_r ? r_r : ROW_W'(r_r - ROW_W'(1));
        cand_col_nxt = pos;
        if (ok && hold_v_r) begin
          state_nxt = ST_PUSH;
        end else begin
          if (ok) begin
            hold_v_nxt   = 1'b1;
            hold_row_nxt = flush_r ? r_r : ROW_W'(r_r - ROW_W'(1));
            hold_col_nxt = pos;
          end
          adv_go = 1'b1;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = hold_row_r;
          out_col_nxt   = hold_col_r;
          out_last_nxt  = 1'b0;
          hold_row_nxt  = cand_row_r;
          hold_col_nxt  = cand_col_r;
          adv_go        = 1'b1;
        end
      end
      ST_DONE: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = hold_row_r;
          out_col_nxt   = hold_col_r;
          out_last_nxt  = 1'b1;
          hold_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // next decision: start or continue the final-row sweep after the last element, else finish
    if (adv_go) begin
      step_nxt = '0;
      if (!flush_r && end_r) begin
        flush_nxt = 1'b1;
        k_nxt     = '0;
        state_nxt = ST_READ;
      end else if (flush_r && e_en) begin
        k_nxt     = COL_W'(k_r + COL_W'(1));
        state_nxt = ST_READ;
      end else begin
        state_nxt = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      base_r      <= 2'd0;
      step_r      <= '0;
      flush_r     <= 1'b0;
      k_r         <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      end_r       <= 1'b0;
    end else begin
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      base_r      <= base_nxt;
      step_r      <= step_nxt;
      flush_r     <= flush_nxt;
      k_r         <= k_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      end_r       <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    cur_r      <= cur_nxt;
    cand_row_r <= cand_row_nxt;
    cand_col_r <= cand_col_nxt;
    hold_row_r <= hold_row_nxt;
    hold_col_r <= hold_col_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
    if (state_r == ST_READ && step_r != 3'd0) nb_r[nb_idx] <= $signed(ram_rdata);
  end

  assign out_m.valid    = out_valid_r;
  assign out_m.peak_row = out_row_r;
  assign out_m.peak_col = PEAK_COL_W'(out_col_r);
  assign out_m.last     = out_last_r;

endmodule
`default_nettype wire

>>> test/tb_matrix_local_peak_finder.sv
// Testbench: self-checking stimulus and peak prediction for matrix_local_peak_finder.
`timescale 1ns / 1ps
module tb_matrix_local_peak_finder;
  import mlpf_pkg::*;

  localparam int VB            = VALUE_BITS_DEF;
  localparam int MAX_C         = MAX_COLS_DEF;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 400;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 270;
  localparam int TALL_ITEMS    = 20;

  typedef struct packed {
    logic [ROW_W-1:0]      row;
    logic [PEAK_COL_W-1:0] col;
    logic                  last;
  } peak_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_HALF,
    RX_SPARSE
  } rx_mode_t;

  typedef enum int unsigned {
    VAL_FULL,
    VAL_NARROW,
    VAL_EDGE,
    VAL_MIXED
  } val_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  tx_valid = 1'b0;
  logic signed [VB-1:0]  tx_value = '0;
  logic                  rx_ready = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  mlpf_in_if #(.VALUE_BITS(VB)) in_if ();
  mlpf_out_if out_if ();

  assign in_if.valid  = tx_valid;
  assign in_if.value  = tx_value;
  assign out_if.ready = rx_ready;

  matrix_local_peak_finder #(
    .MAX_COLS  (MAX_C),
    .VALUE_BITS(VB)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_s   (in_if.sink),
    .out_m  (out_if.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [VB-1:0]  ring [3][MAX_C];
  int unsigned           pos_row = 0;
  int unsigned           pos_col = 0;
  int unsigned           slot = 0;
  logic [ROW_W-1:0]      rows_reg = ROWS_RESET;
  logic [CFG_COLS_W-1:0] cols_reg = COLS_RESET;
  peak_t                 peak_q[$];

  int err_cnt = 0;
  int items_sent = 0;
  int burst_left = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic [5:0] pat_cnt = '0;
  rx_mode_t rx_mode = RX_FREE;

  function automatic int unsigned eff_rows();
    return (rows_reg < 2) ? 2 : int'(rows_reg);
  endfunction

  function automatic int unsigned eff_cols();
    if (cols_reg < 2) return 2;
    if (cols_reg > MAX_C) return MAX_C;
    return int'(cols_reg);
  endfunction

  task automatic predict_peaks(input logic signed [VB-1:0] x);
    int unsigned rows, cols, r, c, cur, up, up2, k;
    logic signed [VB-1:0] v;
    logic ok, held;
    peak_t pend;
    rows = eff_rows();
    cols = eff_cols();
    held = 1'b0;
    pend = '0;
    if (pos_row >= rows || pos_col >= cols) begin
      pos_row = 0;
      pos_col = 0;
      slot = 0;
    end
    r = pos_row;
    c = pos_col;
    cur = slot;
    up = (cur + 2) % 3;
    up2 = (cur + 1) % 3;
    ring[cur][c] = x;
    if (r >= 1) begin
      v = ring[up][c];
      ok = (v >= x);
      if (r >= 2 && v < ring[up2][c]) ok = 1'b0;
      if (c >= 1 && v < ring[up][c-1]) ok = 1'b0;
      if (c + 1 < cols && v < ring[up][c+1]) ok = 1'b0;
      if (ok) begin
        pend = '{row: ROW_W'(r - 1), col: PEAK_COL_W'(c), last: 1'b0};
        held = 1'b1;
      end
    end
    if (r + 1 == rows && c + 1 == cols) begin
      // final row sweep
      for (k = 0; k < cols; k++) begin
        v = ring[cur][k];
        ok = (v >= ring[up][k]);
        if (k >= 1 && v < ring[cur][k-1]) ok = 1'b0;
        if (k + 1 < cols && v < ring[cur][k+1]) ok = 1'b0;
        if (ok) begin
          if (held) peak_q.push_back(pend);
          pend = '{row: ROW_W'(r), col: PEAK_COL_W'(k), last: 1'b0};
          held = 1'b1;
        end
      end
      pos_row = 0;
      pos_col = 0;
      slot = 0;
    end else if (c + 1 == cols) begin
      pos_col = 0;
      pos_row = r + 1;
      slot = (cur + 1) % 3;
    end else begin
      pos_col = c + 1;
    end
    if (held) begin
      pend.last = 1'b1;
      peak_q.push_back(pend);
    end
  endtask

  function automatic logic signed [VB-1:0] rand_value(input val_style_t style);
    val_style_t pick;
    pick = (style == VAL_MIXED) ? val_style_t'($urandom_range(0, 2)) : style;
    case (pick)
      VAL_FULL:   return VB'($urandom);
      VAL_NARROW: return VB'(int'($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 5))
          0:       return {1'b1, {(VB-1){1'b0}}};
          1:       return {1'b0, {(VB-1){1'b1}}};
          2:       return '1;
          3:       return '0;
          4:       return {1'b1, {(VB-2){1'b0}}, 1'b1};
          default: return {1'b0, {(VB-2){1'b1}}, 1'b0};
        endcase
      end
    endcase
  endfunction

  task automatic send_value(input logic signed [VB-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        tx_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    tx_valid <= 1'b1;
    tx_value <= v;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_peaks(v);
    items_sent++;
  endtask

  task automatic send_matrix(input val_style_t style);
    int unsigned n;
    n = eff_rows() * eff_cols();
    repeat (n) send_value(rand_value(style));
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_ROW_COUNT) rows_reg = data[ROW_W-1:0];
    else cols_reg = data[CFG_COLS_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_size(input int unsigned rows, input int unsigned cols);
    apb_write(REG_ROW_COUNT, APB_DATA_W'(rows));
    apb_write(REG_COL_COUNT, APB_DATA_W'(cols));
  endtask

  // block idle: no request offered, nothing outstanding, flush sweep given time to end
  task automatic wait_drained();
    @(negedge clk);
    tx_valid <= 1'b0;
    burst_left = 0;
    while (peak_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(input string what, input peak_t want, input peak_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t: %s: expected row %0d col %0d last %0b, got row %0d col %0d last %0b",
               $time, what, want.row, want.col, want.last, got.row, got.col, got.last);
  endtask

  // result checker
  always @(posedge clk) begin
    peak_t got, want;
    if (rst_n && out_if.valid === 1'b1 && rx_ready) begin
      got = '{row: out_if.peak_row, col: out_if.peak_col, last: out_if.last};
      if (peak_q.size() == 0) begin
        note_mismatch("unexpected peak", '0, got);
      end else begin
        want = peak_q.pop_front();
        if (got !== want) note_mismatch("peak mismatch", want, got);
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    pat_cnt <= pat_cnt + 1'b1;
    if (pat_cnt == '0) rx_mode <= rx_mode_t'($urandom_range(0, 2));
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rx_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      rx_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE: rx_ready <= 1'b1;
        RX_HALF: rx_ready <= 1'($urandom_range(0, 1));
        default: rx_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // reset sizes 2 x 2: ties everywhere, then signed extremes
  task automatic test_reset_size();
    repeat (4) send_value(16'sh7FFF);
    send_value(-16'sh8000);
    send_value(16'sh7FFF);
    send_value(-16'sh0001);
    send_value(16'sh0000);
    wait_drained();
  endtask

  task automatic test_size_clamp_low();
    set_size(0, 1);
    send_value(16'sh5555);
    send_value(-16'sh5556);
    send_value(16'sh0000);
    send_value(16'sh0000);
    wait_drained();
  endtask

  // shrinking cols under the column position restarts the matrix
  task automatic test_size_change();
    set_size(3, 5);
    repeat (7) send_value(rand_value(VAL_NARROW));
    wait_drained();
    apb_write(REG_COL_COUNT, 2);
    repeat (6) send_value(rand_value(VAL_NARROW));
    wait_drained();
  endtask

  task automatic test_output_stall();
    set_size(4, 8);
    hold_reqs++;
    send_matrix(VAL_NARROW);
    wait_drained();
  endtask

  task automatic test_random_matrices();
    int start;
    int unsigned sel, rows, cols;
    val_style_t style;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      rows = $urandom_range(2, 6);
      cols = $urandom_range(2, 10);
      case (sel)
        0: rows = $urandom_range(0, 1);
        1: begin
          rows = $urandom_range(1, 3);
          cols = $urandom_range(33, 63);
        end
        2: cols = ($urandom_range(0, 1) == 0) ? MAX_C : $urandom_range(0, 1);
        default: ;
      endcase
      set_size(rows, cols);
      style = val_style_t'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0 && eff_cols() >= 3) begin
        // broken matrix: cut at column 2 of row 1, then restart with 2 columns
        repeat (eff_cols() + 2) send_value(rand_value(style));
        wait_drained();
        apb_write(REG_COL_COUNT, 2);
      end
      send_matrix(style);
      wait_drained();
    end
  endtask

  // row count at its ceiling: leading rows only, then a shrink restarts the matrix
  task automatic test_max_rows();
    set_size(1023, 2);
    repeat (TALL_ITEMS) send_value(rand_value(VAL_MIXED));
    wait_drained();
    apb_write(REG_ROW_COUNT, 2);
    send_matrix(VAL_MIXED);
    wait_drained();
  endtask

  initial begin
    int drain_wait;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_size();
    test_size_clamp_low();
    test_size_change();
    test_output_stall();
    test_random_matrices();
    test_max_rows();
    drain_wait = 0;
    while (peak_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (peak_q.size() != 0) begin
      err_cnt += peak_q.size();
      $display("%0d expected peaks never arrived", peak_q.size());
    end
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
src/mlpf_pkg.sv
src/mlpf_in_if.sv
src/mlpf_out_if.sv
src/mlpf_cfg.sv
src/mlpf_ram.sv
src/matrix_local_peak_finder.sv
test/tb_matrix_local_peak_finder.sv
